// ===== sv/mfd_pkg.sv =====
// ----------------------------------------------------------------------------
// mfd_pkg
// Shared widths, reset values and register codes of the motor feedback decoder.
// ----------------------------------------------------------------------------
package mfd_pkg;

  localparam int BYTE_W   = 8;
  localparam int COUNT_W  = 16;
  localparam int ANGLE_W  = 24;
  localparam int TURN_W   = 16;
  localparam int TOTAL_W  = 48;
  localparam int FILT_W   = 32;
  localparam int ALPHA_W  = 17;
  localparam int SGAIN_W  = 16;
  localparam int AGAIN_W  = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam int WRAP_THRESHOLD_DEF = 4096;

  localparam logic [ALPHA_W-1:0] SPEED_ALPHA_RST   = 17'd55706;
  localparam logic [ALPHA_W-1:0] CURRENT_ALPHA_RST = 17'd58982;
  localparam logic [SGAIN_W-1:0] SPEED_GAIN_RST    = 16'd1536;
  localparam logic [AGAIN_W-1:0] ANGLE_GAIN_RST    = 24'd737280;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;
  localparam int                 TURN_DEG_W = 9;
  localparam logic [TURN_DEG_W-1:0] TURN_DEG = 9'd360;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPEED_ALPHA   = 2'd0,
    CFG_CURRENT_ALPHA = 2'd1,
    CFG_SPEED_GAIN    = 2'd2,
    CFG_ANGLE_GAIN    = 2'd3
  } cfg_idx_t;

endpackage

// ===== sv/mfd_ifs.sv =====
// ----------------------------------------------------------------------------
// mfd_ifs
// Valid/ready channels: feedback frame in, decoded result out.
// ----------------------------------------------------------------------------
interface mfd_frame_if import mfd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] enc_hi;
  logic [BYTE_W-1:0] enc_lo;
  logic [BYTE_W-1:0] spd_hi;
  logic [BYTE_W-1:0] spd_lo;
  logic [BYTE_W-1:0] cur_hi;
  logic [BYTE_W-1:0] cur_lo;
  logic [BYTE_W-1:0] temp_byte;

  modport source (output valid, enc_hi, enc_lo, spd_hi, spd_lo, cur_hi, cur_lo, temp_byte,
                  input ready);
  modport sink   (input valid, enc_hi, enc_lo, spd_hi, spd_lo, cur_hi, cur_lo, temp_byte,
                  output ready);
endinterface

interface mfd_result_if import mfd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [COUNT_W-1:0]        encoder_count;
  logic [ANGLE_W-1:0]        single_angle;
  logic signed [TURN_W-1:0]  turn_count;
  logic signed [TOTAL_W-1:0] multi_angle;
  logic signed [FILT_W-1:0]  speed_filtered;
  logic signed [FILT_W-1:0]  current_filtered;
  logic [BYTE_W-1:0]         temperature;

  modport source (output valid, encoder_count, single_angle, turn_count, multi_angle,
                  speed_filtered, current_filtered, temperature, input ready);
  modport sink   (input valid, encoder_count, single_angle, turn_count, multi_angle,
                  speed_filtered, current_filtered, temperature, output ready);
endinterface

// ===== sv/mfd_serial_mul.sv =====
// ----------------------------------------------------------------------------
// mfd_serial_mul
// Serial-parallel multiplier: signed multiplicand times unsigned multiplier,
// one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module mfd_serial_mul #(
  parameter int MW = 16,
  parameter int NB = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic signed [MW-1:0]        mcand,
  input  logic [NB-1:0]               mplier,
  output logic                        busy,
  output logic signed [MW+NB-1:0]     product
);

  localparam int CW = $clog2(NB + 1);

  logic signed [MW-1:0] mc;
  logic signed [MW-1:0] hi;
  logic [NB-1:0]        mp;
  logic [NB-1:0]        lo;
  logic [CW-1:0]        cnt;
  logic [MW:0]          sum;

  assign sum     = {hi[MW-1], hi} + (mp[0] ? {mc[MW-1], mc} : {(MW+1){1'b0}});
  assign busy    = (cnt != '0);
  assign product = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(NB);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mc <= mcand;
      mp <= mplier;
      hi <= '0;
      lo <= '0;
    end else if (busy) begin
      hi <= sum[MW:1];
      lo <= {sum[0], lo[NB-1:1]};
      mp <= mp >> 1;
    end
  end

endmodule

// ===== sv/mfd_turn_track.sv =====
// ----------------------------------------------------------------------------
// mfd_turn_track
// Tracks whole encoder turns from jumps of the count, saturating counter.
// ----------------------------------------------------------------------------
module mfd_turn_track import mfd_pkg::*; #(
  parameter int WRAP_THRESHOLD = WRAP_THRESHOLD_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic [COUNT_W-1:0]        count,
  output logic signed [TURN_W-1:0]  turns
);

  localparam int DW = COUNT_W + 2;
  localparam logic signed [DW-1:0] THR_POS = DW'(WRAP_THRESHOLD);
  localparam logic signed [DW-1:0] THR_NEG = -THR_POS;
  localparam logic signed [TURN_W-1:0] TURN_MAX = {1'b0, {(TURN_W-1){1'b1}}};
  localparam logic signed [TURN_W-1:0] TURN_MIN = {1'b1, {(TURN_W-1){1'b0}}};

  logic [COUNT_W-1:0]       prev_encoder;
  logic signed [DW-1:0]     d;
  logic signed [TURN_W-1:0] turns_next;

  assign d = $signed({2'b00, count}) - $signed({2'b00, prev_encoder});

  always_comb begin
    priority if (d > THR_POS && turns != TURN_MIN) begin
      turns_next = turns - 1'b1;
    end else if (d < THR_NEG && turns != TURN_MAX) begin
      turns_next = turns + 1'b1;
    end else begin
      turns_next = turns;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_encoder <= '0;
      turns        <= '0;
    end else if (step) begin
      prev_encoder <= count;
      turns        <= turns_next;
    end
  end

endmodule

// ===== sv/motor_feedback_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// motor_feedback_decoder_unit
// Decodes a motor feedback frame: single and multi-turn angle, low-pass
// filtered speed and current, temperature.
//
//   channel   dir   handshake       contents
//   frame     in    valid/ready     encoder, rpm, current, temperature bytes
//   result    out   valid/ready     count, angles, turns, filtered values
//   cfg       in    cfg_we          cfg_idx selects register, cfg_data value
//
// A frame runs from acceptance to a loaded result in steps: first the
// angle, rpm scaling and current filter products (17-bit weight, one bit
// per cycle), then the speed filter and turn-angle products, then a finish.
// The next frame is accepted the cycle after the load, not before it.
// Reset clears turn tracking and filter state and restores register defaults.
// A waiting result that is not taken holds the finish step and the next frame.
// ----------------------------------------------------------------------------
module motor_feedback_decoder_unit import mfd_pkg::*; #(
  parameter int WRAP_THRESHOLD = WRAP_THRESHOLD_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  mfd_frame_if.sink             frame,
  mfd_result_if.source          result
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL1 = 4'b0010,
    ST_MUL2 = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  localparam int AM_W = AGAIN_W + 1;
  localparam int FM_W = FILT_W + 1;
  localparam int SUM_W = FILT_W + 3;
  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(-64'sd2147483648);

  state_t state, state_next;

  logic [ALPHA_W-1:0] speed_alpha;
  logic [ALPHA_W-1:0] current_alpha;
  logic [SGAIN_W-1:0] speed_gain;
  logic [AGAIN_W-1:0] angle_gain;

  logic signed [FILT_W-1:0] speed_state;
  logic signed [FILT_W-1:0] current_state;

  logic [COUNT_W-1:0] count_q;
  logic [BYTE_W-1:0]  temp_q;

  logic accept;
  logic load;
  logic start2;
  logic [COUNT_W-1:0] count_in;
  logic signed [TURN_W-1:0] turns;

  logic [ALPHA_W-1:0] speed_a;
  logic [ALPHA_W-1:0] current_a;

  logic                               busy_a, busy_b, busy_c, busy_d, busy_e;
  logic signed [AM_W+COUNT_W-1:0]     prod_a;
  logic signed [2*COUNT_W-1:0]        prod_b;
  logic signed [FM_W+ALPHA_W-1:0]     prod_c;
  logic signed [FM_W+ALPHA_W-1:0]     prod_d;
  logic signed [TURN_W+TURN_DEG_W-1:0] prod_e;

  logic signed [FM_W-1:0] cur_x;
  logic signed [FM_W-1:0] spd_diff;
  logic signed [FM_W-1:0] cur_diff;

  logic signed [SUM_W-1:0] speed_sum;
  logic signed [SUM_W-1:0] current_sum;
  logic signed [FILT_W-1:0] speed_next;
  logic signed [FILT_W-1:0] current_next;
  logic [ANGLE_W:0]        single_raw;
  logic [ANGLE_W-1:0]      single;
  logic signed [TOTAL_W-BYTE_W-15:0] total_hi;

  function automatic logic signed [FILT_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    if (v > SAT_MAX) begin
      sat32 = {1'b0, {(FILT_W-1){1'b1}}};
    end else if (v < SAT_MIN) begin
      sat32 = {1'b1, {(FILT_W-1){1'b0}}};
    end else begin
      sat32 = v[FILT_W-1:0];
    end
  endfunction

  assign accept   = frame.valid && frame.ready;
  assign frame.ready = (state == ST_IDLE);
  assign count_in = {frame.enc_hi, frame.enc_lo};
  assign load     = (state == ST_FIN) && (!result.valid || result.ready);
  assign start2   = (state == ST_MUL1) && !busy_a && !busy_b && !busy_d;

  assign speed_a   = speed_alpha[ALPHA_W-1]   ? ALPHA_ONE : speed_alpha;
  assign current_a = current_alpha[ALPHA_W-1] ? ALPHA_ONE : current_alpha;

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_alpha   <= SPEED_ALPHA_RST;
      current_alpha <= CURRENT_ALPHA_RST;
      speed_gain    <= SPEED_GAIN_RST;
      angle_gain    <= ANGLE_GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_SPEED_ALPHA:   speed_alpha   <= cfg_data[ALPHA_W-1:0];
        CFG_CURRENT_ALPHA: current_alpha <= cfg_data[ALPHA_W-1:0];
        CFG_SPEED_GAIN:    speed_gain    <= cfg_data[SGAIN_W-1:0];
        CFG_ANGLE_GAIN:    angle_gain    <= cfg_data[AGAIN_W-1:0];
      endcase
    end
  end

  mfd_turn_track #(
    .WRAP_THRESHOLD(WRAP_THRESHOLD)
  ) u_turn (
    .clk   (clk),
    .rst   (rst),
    .step  (accept),
    .count (count_in),
    .turns (turns)
  );

  assign cur_x    = $signed({{(FM_W-2*BYTE_W-BYTE_W){frame.cur_hi[BYTE_W-1]}},
                             frame.cur_hi, frame.cur_lo, {BYTE_W{1'b0}}});
  assign cur_diff = cur_x - $signed({current_state[FILT_W-1], current_state});
  assign spd_diff = $signed({prod_b[2*COUNT_W-1], prod_b})
                  - $signed({speed_state[FILT_W-1], speed_state});

  mfd_serial_mul #(.MW(AM_W), .NB(COUNT_W)) u_mul_angle (
    .clk(clk), .rst(rst), .start(accept),
    .mcand($signed({1'b0, angle_gain})), .mplier(count_in),
    .busy(busy_a), .product(prod_a)
  );

  mfd_serial_mul #(.MW(COUNT_W), .NB(SGAIN_W)) u_mul_rpm (
    .clk(clk), .rst(rst), .start(accept),
    .mcand($signed({frame.spd_hi, frame.spd_lo})), .mplier(speed_gain),
    .busy(busy_b), .product(prod_b)
  );

  mfd_serial_mul #(.MW(FM_W), .NB(ALPHA_W)) u_mul_cur (
    .clk(clk), .rst(rst), .start(accept),
    .mcand(cur_diff), .mplier(current_a),
    .busy(busy_d), .product(prod_d)
  );

  mfd_serial_mul #(.MW(FM_W), .NB(ALPHA_W)) u_mul_spd (
    .clk(clk), .rst(rst), .start(start2),
    .mcand(spd_diff), .mplier(speed_a),
    .busy(busy_c), .product(prod_c)
  );

  mfd_serial_mul #(.MW(TURN_W), .NB(TURN_DEG_W)) u_mul_turn (
    .clk(clk), .rst(rst), .start(start2),
    .mcand(turns), .mplier(TURN_DEG),
    .busy(busy_e), .product(prod_e)
  );

  // finish: round, saturate, combine
  assign speed_sum = $signed({{3{speed_state[FILT_W-1]}}, speed_state})
                   + $signed({prod_c[FM_W+ALPHA_W-1], prod_c[FM_W+ALPHA_W-1:16]})
                   + $signed({{(SUM_W-1){1'b0}}, prod_c[15]});
  assign current_sum = $signed({{3{current_state[FILT_W-1]}}, current_state})
                     + $signed({prod_d[FM_W+ALPHA_W-1], prod_d[FM_W+ALPHA_W-1:16]})
                     + $signed({{(SUM_W-1){1'b0}}, prod_d[15]});
  assign speed_next   = sat32(speed_sum);
  assign current_next = sat32(current_sum);

  assign single_raw = prod_a[ANGLE_W+16:16] + {{ANGLE_W{1'b0}}, prod_a[15]};
  assign single     = single_raw[ANGLE_W] ? {ANGLE_W{1'b1}} : single_raw[ANGLE_W-1:0];
  assign total_hi   = $signed({prod_e[TURN_W+TURN_DEG_W-1], prod_e})
                    + $signed({10'b0, single[ANGLE_W-1:BYTE_W]});

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_MUL1;
      ST_MUL1: if (start2) state_next = ST_MUL2;
      ST_MUL2: if (!busy_c && !busy_e) state_next = ST_FIN;
      ST_FIN:  if (load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      speed_state   <= '0;
      current_state <= '0;
      result.valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        speed_state   <= speed_next;
        current_state <= current_next;
        result.valid  <= 1'b1;
      end else if (result.ready) begin
        result.valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      count_q <= count_in;
      temp_q  <= frame.temp_byte;
    end
    if (load) begin
      result.encoder_count    <= count_q;
      result.single_angle     <= single;
      result.turn_count       <= turns;
      result.multi_angle      <= {{(TOTAL_W-BYTE_W-26){total_hi[25]}}, total_hi,
                                  single[BYTE_W-1:0]};
      result.speed_filtered   <= speed_next;
      result.current_filtered <= current_next;
      result.temperature      <= temp_q;
    end
  end

endmodule
